// ----- design/ftcd_pkg.sv -----
package ftcd_pkg;

   localparam int TAG_W = 36;
   localparam int SLOT_W = 6;
   localparam int HANDLE_W = 32;

   typedef enum logic [1:0] {
      CMD_LOOKUP       = 2'd0,
      CMD_LOOKUP_ALLOC = 2'd1,
      CMD_FORCE_ALLOC  = 2'd2,
      CMD_INVALIDATE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  level;
      logic [15:0] tile_col;
      logic [15:0] tile_row;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic                allocated;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

// ----- design/fifo_tile_cache_directory.sv -----
// Fully associative tile directory with first-in first-out replacement.
// An item is taken on req_item at a rising edge where start is high and busy
// is low. Each item yields exactly one result on rsp_item, shown for one
// cycle with rsp_strobe high; the receiver cannot hold results off.
// The directory lives in one synchronous memory of {valid, tag} entries.
// A lookup scans it one entry per cycle through the single read port and
// stops at the first match; a hit answers from the scan, a lookup miss
// answers once the last entry has been checked, and a lookup-or-allocate
// miss then goes on to allocate the next slot after the fill pointer.
// A force allocate goes straight to that allocate step without a scan.
// An invalidate-all sweeps the memory one entry per cycle through the write
// port and responds once the sweep is done.
// A new item can be taken in the cycle its predecessor's result is shown.
// After reset the same sweep runs with busy high and no result; csr_wr_data
// is written to the handle base whenever csr_wr_en is high, and reset sets
// the handle base to 1.
module fifo_tile_cache_directory #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ftcd_pkg::req_type             req_item,
   output logic                          rsp_strobe,
   output ftcd_pkg::rsp_type             rsp_item,
   input  logic                          csr_wr_en,
   input  logic [ftcd_pkg::HANDLE_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(CACHE_DEPTH);

   logic [ftcd_pkg::HANDLE_W-1:0] base_ff;
   logic mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [IDX_W-1:0] mem_rd_addr;
   ftcd_pkg::entry_type mem_wr_data;
   ftcd_pkg::entry_type mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= ftcd_pkg::HANDLE_W'(1);
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   ftcd_tag_ram #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ftcd_ctrl #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .handle_base (base_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_hit_xor_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.hit && rsp_item.allocated))
      else $error("result is both hit and allocated");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.hit && !rsp_item.allocated) |->
      (rsp_item.slot == '0) && (rsp_item.handle == '0))
      else $error("miss result carries a slot or handle");

endmodule

// ----- design/ftcd_tag_ram.sv -----
module ftcd_tag_ram #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(CACHE_DEPTH)-1:0]   wr_addr,
   input  ftcd_pkg::entry_type              wr_data,
   input  logic [$clog2(CACHE_DEPTH)-1:0]   rd_addr,
   output ftcd_pkg::entry_type              rd_data
);

   ftcd_pkg::entry_type mem [CACHE_DEPTH];
   ftcd_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ftcd_ctrl.sv -----
module ftcd_ctrl #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  ftcd_pkg::req_type                      req_item,
   input  logic [ftcd_pkg::HANDLE_W-1:0]          handle_base,
   output logic                                   rsp_strobe,
   output ftcd_pkg::rsp_type                      rsp_item,
   output logic                                   mem_wr_en,
   output logic [$clog2(CACHE_DEPTH)-1:0]         mem_wr_addr,
   output ftcd_pkg::entry_type                    mem_wr_data,
   output logic [$clog2(CACHE_DEPTH)-1:0]         mem_rd_addr,
   input  ftcd_pkg::entry_type                    mem_rd_data
);

   localparam int IDX_W = $clog2(CACHE_DEPTH);
   localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CACHE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_DEPTH - 1);

   ftcd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   ftcd_pkg::rsp_type rsp_ff, rsp_in;
   ftcd_pkg::cmd_type cmd_ff, cmd_in;
   logic [ftcd_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic match;
   logic [IDX_W-1:0] ptr_next;

   assign match = mem_rd_data.valid && (mem_rd_data.tag == tag_ff);
   assign ptr_next = (ptr_ff == IDX_LAST) ? '0 : ptr_ff + 1'b1;
   assign mem_rd_addr = addr_ff[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ftcd_pkg::ST_CLEAR: begin
            if (addr_ff == CNT_LAST) begin
               state_in = ftcd_pkg::ST_IDLE;
            end
         end
         ftcd_pkg::ST_IDLE: begin
            if (start) begin
               case (req_item.cmd)
                  ftcd_pkg::CMD_INVALIDATE:  state_in = ftcd_pkg::ST_CLEAR;
                  ftcd_pkg::CMD_FORCE_ALLOC: state_in = ftcd_pkg::ST_ALLOC;
                  default:                   state_in = ftcd_pkg::ST_SCAN;
               endcase
            end
         end
         ftcd_pkg::ST_SCAN: begin
            if (chk_vld_ff) begin
               if (match) begin
                  state_in = ftcd_pkg::ST_IDLE;
               end else if (chk_idx_ff == IDX_LAST) begin
                  state_in = (cmd_ff == ftcd_pkg::CMD_LOOKUP) ? ftcd_pkg::ST_IDLE
                                                               : ftcd_pkg::ST_ALLOC;
               end
            end
         end
         ftcd_pkg::ST_ALLOC: begin
            state_in = ftcd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ftcd_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = addr_ff[IDX_W-1:0];
      ptr_in = ptr_ff;
      clr_rsp_in = clr_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      cmd_in = cmd_ff;
      tag_in = tag_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = addr_ff[IDX_W-1:0];
      mem_wr_data = '0;
      case (state_ff)
         ftcd_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == CNT_LAST) begin
               addr_in = '0;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '0;
               end
            end
         end
         ftcd_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in = req_item.cmd;
               tag_in = {req_item.level, req_item.tile_col, req_item.tile_row};
               addr_in = '0;
               clr_rsp_in = (req_item.cmd == ftcd_pkg::CMD_INVALIDATE);
            end
         end
         ftcd_pkg::ST_SCAN: begin
            if (addr_ff != CNT_END) begin
               chk_vld_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (match) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.hit = 1'b1;
                  rsp_in.allocated = 1'b0;
                  rsp_in.slot = ftcd_pkg::SLOT_W'(chk_idx_ff);
                  rsp_in.handle = handle_base + ftcd_pkg::HANDLE_W'(chk_idx_ff);
               end else if ((chk_idx_ff == IDX_LAST) &&
                            (cmd_ff == ftcd_pkg::CMD_LOOKUP)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '0;
               end
            end
         end
         ftcd_pkg::ST_ALLOC: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = ptr_next;
            mem_wr_data.valid = 1'b1;
            mem_wr_data.tag = tag_ff;
            ptr_in = ptr_next;
            rsp_strobe_in = 1'b1;
            rsp_in.hit = 1'b0;
            rsp_in.allocated = 1'b1;
            rsp_in.slot = ftcd_pkg::SLOT_W'(ptr_next);
            rsp_in.handle = handle_base + ftcd_pkg::HANDLE_W'(ptr_next);
         end
         default: begin
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftcd_pkg::ST_CLEAR;
         addr_ff <= '0;
         chk_vld_ff <= 1'b0;
         ptr_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         chk_vld_ff <= chk_vld_in;
         ptr_ff <= ptr_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      rsp_ff <= rsp_in;
      cmd_ff <= cmd_in;
      tag_ff <= tag_in;
   end

   assign busy = (state_ff != ftcd_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// ----- test/tile_directory_checker.sv -----
`timescale 1ns / 100ps
module tile_directory_checker #(
   parameter int CACHE_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  ftcd_pkg::req_type             req_item,
   input  logic                          rsp_strobe,
   input  ftcd_pkg::rsp_type             rsp_item,
   input  logic                          csr_wr_en,
   input  logic [ftcd_pkg::HANDLE_W-1:0] csr_wr_data,
   output int                            mismatches,
   output int                            pending
);

   logic                          tile_valid [CACHE_DEPTH];
   logic [ftcd_pkg::TAG_W-1:0]    tile_tag [CACHE_DEPTH];
   int                            fill_ptr;
   logic [ftcd_pkg::HANDLE_W-1:0] handle_base;
   ftcd_pkg::rsp_type             awaited_results [$];
   ftcd_pkg::rsp_type             oldest;

   function automatic ftcd_pkg::rsp_type make_result(logic hit, logic allocated, int slot);
      ftcd_pkg::rsp_type r;
      r.hit = hit;
      r.allocated = allocated;
      r.slot = slot[ftcd_pkg::SLOT_W-1:0];
      r.handle = (hit || allocated) ? ftcd_pkg::HANDLE_W'(slot) + handle_base : '0;
      return r;
   endfunction

   function automatic ftcd_pkg::rsp_type resolve_request(ftcd_pkg::req_type r);
      logic [ftcd_pkg::TAG_W-1:0] tag;
      tag = {r.level, r.tile_col, r.tile_row};
      if (r.cmd == ftcd_pkg::CMD_INVALIDATE) begin
         foreach (tile_valid[i]) tile_valid[i] = 1'b0;
         return make_result(1'b0, 1'b0, 0);
      end
      if (r.cmd != ftcd_pkg::CMD_FORCE_ALLOC) begin
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (tile_valid[i] && tile_tag[i] == tag) return make_result(1'b1, 1'b0, i);
         end
         if (r.cmd == ftcd_pkg::CMD_LOOKUP) return make_result(1'b0, 1'b0, 0);
      end
      fill_ptr = (fill_ptr + 1) % CACHE_DEPTH;
      tile_tag[fill_ptr] = tag;
      tile_valid[fill_ptr] = 1'b1;
      return make_result(1'b0, 1'b1, fill_ptr);
   endfunction

   function automatic void compare_field(string field, logic [31:0] expected,
                                         logic [31:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (tile_valid[i]) tile_valid[i] = 1'b0;
         fill_ptr = 0;
         handle_base = 1;
         mismatches = 0;
         awaited_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_item);
            end else begin
               oldest = awaited_results.pop_front();
               compare_field("hit", 32'(oldest.hit), 32'(rsp_item.hit));
               compare_field("allocated", 32'(oldest.allocated), 32'(rsp_item.allocated));
               compare_field("slot", 32'(oldest.slot), 32'(rsp_item.slot));
               compare_field("handle", oldest.handle, rsp_item.handle);
            end
         end
         if (csr_wr_en) handle_base = csr_wr_data;
         if (start && !busy) awaited_results.push_back(resolve_request(req_item));
      end
      pending = awaited_results.size();
   end

endmodule

// ----- test/fifo_tile_cache_directory_test.sv -----
`timescale 1ns / 100ps
module fifo_tile_cache_directory_test;

   localparam int CACHE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 400;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   ftcd_pkg::req_type             req_item = '0;
   logic                          rsp_strobe;
   ftcd_pkg::rsp_type             rsp_item;
   logic                          csr_wr_en = 1'b0;
   logic [ftcd_pkg::HANDLE_W-1:0] csr_wr_data = '0;
   int                            mismatches;
   int                            pending;
   int                            cycles = 0;
   ftcd_pkg::req_type             tile_pool [16];
   int                            idle_pct [3] = '{30, 78, 0};
   logic [ftcd_pkg::HANDLE_W-1:0] phase_base [3];

   fifo_tile_cache_directory #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   tile_directory_checker #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic ftcd_pkg::req_type tile_request(ftcd_pkg::cmd_type cmd,
                                                      logic [3:0] level,
                                                      logic [15:0] col,
                                                      logic [15:0] row);
      ftcd_pkg::req_type r;
      r.cmd = cmd;
      r.level = level;
      r.tile_col = col;
      r.tile_row = row;
      return r;
   endfunction

   function automatic ftcd_pkg::req_type random_request();
      int pick;
      ftcd_pkg::req_type r;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 85) begin
         r = tile_pool[$urandom_range(15)];
      end else begin
         r.level = 4'($urandom);
         r.tile_col = 16'($urandom);
         r.tile_row = 16'($urandom);
      end
      if (pick < 35) r.cmd = ftcd_pkg::CMD_LOOKUP;
      else if (pick < 70) r.cmd = ftcd_pkg::CMD_LOOKUP_ALLOC;
      else if (pick < 97) r.cmd = ftcd_pkg::CMD_FORCE_ALLOC;
      else r.cmd = ftcd_pkg::CMD_INVALIDATE;
      return r;
   endfunction

   task automatic refill_pool();
      tile_pool[0] = tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000);
      tile_pool[1] = tile_request(ftcd_pkg::CMD_LOOKUP, 4'hF, 16'hFFFF, 16'hFFFF);
      for (int i = 2; i < 16; i++) begin
         tile_pool[i] = tile_request(ftcd_pkg::CMD_LOOKUP, 4'($urandom),
                                     16'($urandom), 16'($urandom));
      end
   endtask

   task automatic send_item(ftcd_pkg::req_type item, int idle);
      while ($urandom_range(99) < idle) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_base(logic [ftcd_pkg::HANDLE_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      phase_base[0] = $urandom;
      if (phase_base[0] == 0) phase_base[0] = 1;
      phase_base[1] = 32'h0000_0001;
      phase_base[2] = 32'hFFFF_FFE0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP_ALLOC, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP_ALLOC, 4'hF, 16'hFFFF, 16'hFFFF), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP_ALLOC, 4'hF, 16'hFFFF, 16'hFFFF), 0);
      send_item(tile_request(ftcd_pkg::CMD_FORCE_ALLOC, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'hF, 16'hFFFF, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'hFFFF), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'hF, 16'h0000, 16'hFFFF), 0);
      send_item(tile_request(ftcd_pkg::CMD_FORCE_ALLOC, 4'hA, 16'h5555, 16'hAAAA), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'hA, 16'h5555, 16'hAAAA), 0);
      send_item(tile_request(ftcd_pkg::CMD_INVALIDATE, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP_ALLOC, 4'h0, 16'h0000, 16'h0000), 0);
      drain();
      write_base(32'hFFFF_FFFF);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP, 4'h0, 16'h0000, 16'h0000), 0);
      send_item(tile_request(ftcd_pkg::CMD_FORCE_ALLOC, 4'h5, 16'h1234, 16'h4321), 0);
      send_item(tile_request(ftcd_pkg::CMD_LOOKUP_ALLOC, 4'h5, 16'h1234, 16'h4321), 0);
      send_item(tile_request(ftcd_pkg::CMD_INVALIDATE, 4'hF, 16'hFFFF, 16'hFFFF), 0);

      for (int phase = 0; phase < 3; phase++) begin
         drain();
         write_base(phase_base[phase]);
         refill_pool();
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(149) == 0) drain();
            send_item(random_request(), idle_pct[phase]);
         end
      end

      drain();
      repeat (CACHE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
